@@ rtl/i2cgp_pkg.sv @@
// ----------------------------------------------------------------------------
// i2cgp_pkg
// Shared types and constants for the I2C gyro poll master.
// ----------------------------------------------------------------------------
package i2cgp_pkg;

    // Burst length and recovery pulse count
    localparam int BURST_BYTES     = 6;
    localparam int RECOVERY_PULSES = 10;

    // Counter widths
    localparam int BIT_CNT_W  = 4;
    localparam int BYTE_CNT_W = 3;

    // Command codes carried in s_tuser
    localparam logic [1:0] OP_TICK  = 2'd0;
    localparam logic [1:0] OP_WRITE = 2'd1;
    localparam logic [1:0] OP_POLL  = 2'd2;
    localparam logic [1:0] OP_RECOV = 2'd3;

    // Configuration register indexes
    localparam logic [1:0] CFG_DEVICE_ADDRESS = 2'd0;
    localparam logic [1:0] CFG_WAKE_THRESHOLD = 2'd1;
    localparam logic [1:0] CFG_GYRO_FIRST_REG = 2'd2;
    localparam logic [1:0] CFG_POWER_REG      = 2'd3;

    // Configuration reset values
    localparam logic [6:0] DEVICE_ADDRESS_RST = 7'h68;
    localparam logic [7:0] WAKE_THRESHOLD_RST = 8'd30;
    localparam logic [7:0] GYRO_FIRST_REG_RST = 8'h43;
    localparam logic [7:0] POWER_REG_RST      = 8'h6B;

    // Value written to the power register on an automatic wake
    localparam logic [7:0] WAKE_VALUE = 8'h00;
    localparam logic [7:0] ERR_RUN_MAX = 8'hFF;

    typedef struct packed {
        logic [6:0] device_address;
        logic [7:0] wake_threshold;
        logic [7:0] gyro_first_register;
        logic [7:0] power_register;
    } cfg_t;

    typedef struct packed {
        logic [1:0] op;
        logic       sda_in;
        logic [7:0] reg_addr;
        logic [7:0] reg_data;
    } item_t;

    typedef struct packed {
        logic               wake_issued;
        logic signed [15:0] gyro_z;
        logic signed [15:0] gyro_y;
        logic signed [15:0] gyro_x;
        logic               sample_valid;
        logic               busy_res;
        logic               sda_out;
        logic               scl_out;
    } result_t;

endpackage

@@ rtl/i2cgp_cfg.sv @@
// ----------------------------------------------------------------------------
// i2cgp_cfg
// Configuration register file with a plain write port.
// ----------------------------------------------------------------------------
module i2cgp_cfg
    import i2cgp_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       cfg_we,
    input  logic [1:0] cfg_addr,
    input  logic [7:0] cfg_wdata,
    output cfg_t       cfg
);

    cfg_t cfg_reg;

    // Write one register per enabled cycle
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.device_address      <= DEVICE_ADDRESS_RST;
            cfg_reg.wake_threshold      <= WAKE_THRESHOLD_RST;
            cfg_reg.gyro_first_register <= GYRO_FIRST_REG_RST;
            cfg_reg.power_register      <= POWER_REG_RST;
        end else if (cfg_we) begin
            unique case (cfg_addr)
                CFG_DEVICE_ADDRESS: cfg_reg.device_address      <= cfg_wdata[6:0];
                CFG_WAKE_THRESHOLD: cfg_reg.wake_threshold      <= cfg_wdata;
                CFG_GYRO_FIRST_REG: cfg_reg.gyro_first_register <= cfg_wdata;
                CFG_POWER_REG:      cfg_reg.power_register      <= cfg_wdata;
                default:            cfg_reg <= cfg_reg;
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule

@@ rtl/i2cgp_seq.sv @@
// ----------------------------------------------------------------------------
// i2cgp_seq
// Bus sequencer: one SCL/SDA period per tick word, command loading,
// burst capture and the wake-on-error logic.
// ----------------------------------------------------------------------------
module i2cgp_seq
    import i2cgp_pkg::*;
(
    input  logic    aclk,
    input  logic    aresetn,
    input  logic    fire,
    input  item_t   item,
    input  cfg_t    cfg,
    output result_t res
);

    typedef enum logic [1:0] {
        K_IDLE  = 2'd0,
        K_WRITE = 2'd1,
        K_POLL  = 2'd2,
        K_RECOV = 2'd3
    } kind_t;

    // Write / poll phases
    localparam logic [3:0] PH_S0 = 4'd0;
    localparam logic [3:0] PH_S1 = 4'd1;
    localparam logic [3:0] PH_S2 = 4'd2;
    localparam logic [3:0] PH_BS = 4'd3;
    localparam logic [3:0] PH_BH = 4'd4;
    localparam logic [3:0] PH_BL = 4'd5;
    localparam logic [3:0] PH_AH = 4'd6;
    localparam logic [3:0] PH_AL = 4'd7;
    localparam logic [3:0] PH_RH = 4'd8;
    localparam logic [3:0] PH_RL = 4'd9;
    localparam logic [3:0] PH_KS = 4'd10;
    localparam logic [3:0] PH_KH = 4'd11;
    localparam logic [3:0] PH_KL = 4'd12;
    localparam logic [3:0] PH_T0 = 4'd13;
    localparam logic [3:0] PH_T1 = 4'd14;
    // Recovery phases
    localparam logic [3:0] RC_Q0 = 4'd0;
    localparam logic [3:0] RC_QH = 4'd1;
    localparam logic [3:0] RC_QL = 4'd2;
    localparam logic [3:0] RC_X0 = 4'd3;
    localparam logic [3:0] RC_T0 = 4'd4;
    localparam logic [3:0] RC_T1 = 4'd5;

    localparam logic [BIT_CNT_W-1:0]  BIT_LAST   = BIT_CNT_W'(7);
    localparam logic [BIT_CNT_W-1:0]  PULSE_LAST = BIT_CNT_W'(RECOVERY_PULSES - 1);
    localparam logic [BYTE_CNT_W-1:0] BYTE_LAST  = BYTE_CNT_W'(BURST_BYTES - 1);
    localparam logic [BYTE_CNT_W-1:0] BYTE_NUM   = BYTE_CNT_W'(BURST_BYTES);
    localparam logic [BYTE_CNT_W-1:0] BYTE_ONE   = BYTE_CNT_W'(1);
    localparam logic [BYTE_CNT_W-1:0] BYTE_TWO   = BYTE_CNT_W'(2);

    kind_t                 kind_reg, kind_next;
    logic [3:0]            phase_reg, phase_next;
    logic [BIT_CNT_W-1:0]  bit_cnt_reg, bit_cnt_next;
    logic [BYTE_CNT_W-1:0] byte_cnt_reg, byte_cnt_next;
    logic [7:0]            shift_reg, shift_next;
    logic [7:0]            err_run_reg, err_run_next;
    logic                  scl_reg, scl_next;
    logic                  sda_reg, sda_next;
    logic [15:0]           pend_reg, pend_next;
    logic [7:0]            burst_reg [BURST_BYTES];
    logic                  burst_we;

    logic [7:0]  addr_w;
    logic        msb;
    logic        ackbit;
    logic [7:0]  err_inc;
    logic [15:0] word_x, word_y, word_z;
    logic        all_ones;
    logic        poll_done;
    logic        wake;

    // Burst words, big endian
    assign word_x = {burst_reg[0], burst_reg[1]};
    assign word_y = {burst_reg[2], burst_reg[3]};
    assign word_z = {burst_reg[4], burst_reg[5]};

    assign addr_w   = {cfg.device_address, 1'b0};
    assign msb      = shift_reg[7];
    assign ackbit   = (byte_cnt_reg >= BYTE_LAST);
    assign all_ones = (word_x == 16'hFFFF) && (word_y == 16'hFFFF) && (word_z == 16'hFFFF);
    assign err_inc  = (err_run_reg < ERR_RUN_MAX) ? err_run_reg + 8'd1 : err_run_reg;

    // Next state for one word
    always_comb begin
        kind_next     = kind_reg;
        phase_next    = phase_reg;
        bit_cnt_next  = bit_cnt_reg;
        byte_cnt_next = byte_cnt_reg;
        shift_next    = shift_reg;
        err_run_next  = err_run_reg;
        scl_next      = scl_reg;
        sda_next      = sda_reg;
        pend_next     = pend_reg;
        burst_we      = 1'b0;
        poll_done     = 1'b0;
        wake          = 1'b0;

        if (item.op != OP_TICK) begin
            // Load a command only while idle; drop it otherwise
            if (kind_reg == K_IDLE) begin
                bit_cnt_next  = '0;
                byte_cnt_next = '0;
                shift_next    = '0;
                phase_next    = PH_S0;
                unique case (item.op)
                    OP_WRITE: begin
                        kind_next = K_WRITE;
                        pend_next = {item.reg_addr, item.reg_data};
                    end
                    OP_POLL:  kind_next = K_POLL;
                    default:  begin
                        kind_next  = K_RECOV;
                        phase_next = RC_Q0;
                    end
                endcase
            end
        end else if (kind_reg == K_RECOV) begin
            unique case (phase_reg)
                RC_Q0: begin
                    sda_next   = 1'b1;
                    phase_next = RC_QH;
                end
                RC_QH: begin
                    scl_next   = 1'b1;
                    sda_next   = 1'b1;
                    phase_next = RC_QL;
                end
                RC_QL: begin
                    scl_next = 1'b0;
                    sda_next = 1'b1;
                    if (bit_cnt_reg >= PULSE_LAST) begin
                        phase_next = RC_X0;
                    end else begin
                        bit_cnt_next = bit_cnt_reg + BIT_CNT_W'(1);
                        phase_next   = RC_QH;
                    end
                end
                RC_X0: begin
                    scl_next   = 1'b0;
                    sda_next   = 1'b0;
                    phase_next = RC_T0;
                end
                RC_T0: begin
                    scl_next   = 1'b1;
                    sda_next   = 1'b0;
                    phase_next = RC_T1;
                end
                RC_T1: begin
                    scl_next   = 1'b1;
                    sda_next   = 1'b1;
                    kind_next  = K_IDLE;
                    phase_next = '0;
                end
                default: begin
                    kind_next  = K_IDLE;
                    phase_next = '0;
                end
            endcase
        end else if (kind_reg != K_IDLE) begin
            unique case (phase_reg)
                PH_S0: begin
                    scl_next   = 1'b1;
                    sda_next   = 1'b1;
                    phase_next = PH_S1;
                end
                PH_S1: begin
                    scl_next   = 1'b1;
                    sda_next   = 1'b0;
                    phase_next = PH_S2;
                end
                PH_S2: begin
                    scl_next     = 1'b0;
                    sda_next     = 1'b0;
                    shift_next   = (kind_reg == K_POLL && byte_cnt_reg == BYTE_TWO)
                                   ? (addr_w | 8'h01) : addr_w;
                    bit_cnt_next = '0;
                    phase_next   = PH_BS;
                end
                PH_BS: begin
                    scl_next   = 1'b0;
                    sda_next   = msb;
                    phase_next = PH_BH;
                end
                PH_BH: begin
                    scl_next   = 1'b1;
                    sda_next   = msb;
                    phase_next = PH_BL;
                end
                PH_BL: begin
                    scl_next   = 1'b0;
                    sda_next   = msb;
                    shift_next = {shift_reg[6:0], 1'b0};
                    if (bit_cnt_reg >= BIT_LAST) begin
                        phase_next = PH_AH;
                    end else begin
                        bit_cnt_next = bit_cnt_reg + BIT_CNT_W'(1);
                        phase_next   = PH_BS;
                    end
                end
                PH_AH: begin
                    scl_next   = 1'b1;
                    sda_next   = 1'b1;
                    phase_next = PH_AL;
                end
                PH_AL: begin
                    // Slave acknowledge is clocked but ignored
                    scl_next     = 1'b0;
                    sda_next     = 1'b1;
                    bit_cnt_next = '0;
                    if (byte_cnt_reg == '0) begin
                        byte_cnt_next = BYTE_ONE;
                        shift_next    = (kind_reg == K_POLL) ? cfg.gyro_first_register
                                                             : pend_reg[15:8];
                        phase_next    = PH_BS;
                    end else if (byte_cnt_reg == BYTE_ONE) begin
                        byte_cnt_next = BYTE_TWO;
                        if (kind_reg == K_POLL) begin
                            phase_next = PH_S0;
                        end else begin
                            shift_next = pend_reg[7:0];
                            phase_next = PH_BS;
                        end
                    end else if (kind_reg == K_POLL) begin
                        byte_cnt_next = '0;
                        shift_next    = '0;
                        phase_next    = PH_RH;
                    end else begin
                        phase_next = PH_T0;
                    end
                end
                PH_RH: begin
                    scl_next   = 1'b1;
                    sda_next   = 1'b1;
                    shift_next = {shift_reg[6:0], item.sda_in};
                    phase_next = PH_RL;
                end
                PH_RL: begin
                    scl_next = 1'b0;
                    sda_next = 1'b1;
                    if (bit_cnt_reg >= BIT_LAST) begin
                        burst_we   = (byte_cnt_reg < BYTE_NUM);
                        phase_next = PH_KS;
                    end else begin
                        bit_cnt_next = bit_cnt_reg + BIT_CNT_W'(1);
                        phase_next   = PH_RH;
                    end
                end
                PH_KS: begin
                    scl_next   = 1'b0;
                    sda_next   = ackbit;
                    phase_next = PH_KH;
                end
                PH_KH: begin
                    scl_next   = 1'b1;
                    sda_next   = ackbit;
                    phase_next = PH_KL;
                end
                PH_KL: begin
                    scl_next = 1'b0;
                    sda_next = ackbit;
                    if (ackbit) begin
                        phase_next = PH_T0;
                    end else begin
                        byte_cnt_next = byte_cnt_reg + BYTE_ONE;
                        bit_cnt_next  = '0;
                        shift_next    = '0;
                        phase_next    = PH_RH;
                    end
                end
                PH_T0: begin
                    scl_next   = 1'b1;
                    sda_next   = 1'b0;
                    phase_next = PH_T1;
                end
                PH_T1: begin
                    scl_next   = 1'b1;
                    sda_next   = 1'b1;
                    kind_next  = K_IDLE;
                    phase_next = '0;
                    if (kind_reg == K_POLL) begin
                        poll_done = 1'b1;
                        if (all_ones) begin
                            err_run_next = err_inc;
                            if (err_inc >= cfg.wake_threshold) begin
                                // Run of dead polls: write the wake value
                                err_run_next  = '0;
                                wake          = 1'b1;
                                pend_next     = {cfg.power_register, WAKE_VALUE};
                                byte_cnt_next = '0;
                                kind_next     = K_WRITE;
                                phase_next    = PH_S0;
                            end
                        end else begin
                            err_run_next = '0;
                        end
                    end
                end
                default: begin
                    kind_next  = K_IDLE;
                    phase_next = '0;
                end
            endcase
        end
    end

    // Hold sequencer state, advance on each accepted word
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            kind_reg     <= K_IDLE;
            phase_reg    <= '0;
            bit_cnt_reg  <= '0;
            byte_cnt_reg <= '0;
            shift_reg    <= '0;
            err_run_reg  <= '0;
            scl_reg      <= 1'b1;
            sda_reg      <= 1'b1;
            pend_reg     <= '0;
        end else if (fire) begin
            kind_reg     <= kind_next;
            phase_reg    <= phase_next;
            bit_cnt_reg  <= bit_cnt_next;
            byte_cnt_reg <= byte_cnt_next;
            shift_reg    <= shift_next;
            err_run_reg  <= err_run_next;
            scl_reg      <= scl_next;
            sda_reg      <= sda_next;
            pend_reg     <= pend_next;
        end
    end

    // Capture one burst byte per slot
    always_ff @(posedge aclk) begin
        for (int i = 0; i < BURST_BYTES; i++) begin
            if (fire && burst_we && byte_cnt_reg == BYTE_CNT_W'(i)) begin
                burst_reg[i] <= shift_reg;
            end
        end
    end

    // Result for this word
    always_comb begin
        res.scl_out      = scl_next;
        res.sda_out      = sda_next;
        res.busy_res     = (kind_next != K_IDLE);
        res.sample_valid = poll_done;
        res.gyro_x       = poll_done ? word_x : '0;
        res.gyro_y       = poll_done ? word_y : '0;
        res.gyro_z       = poll_done ? word_z : '0;
        res.wake_issued  = wake;
    end

endmodule

@@ rtl/i2c_gyro_poll_master.sv @@
// ----------------------------------------------------------------------------
// i2c_gyro_poll_master
// Bit-banged I2C master that polls a three-axis gyro and writes its registers.
// ----------------------------------------------------------------------------
// Usage:
//   The slave-side stream takes one word per bus period or command. s_tuser
//   carries the op (tick, register write, gyro poll, bus recovery); a tick
//   word advances the bus by one delay period and carries the sampled SDA.
//   Commands are loaded only while idle and are dropped while a sequence runs.
//   Every input word yields exactly one result word on the master side with
//   the SCL/SDA levels to drive, busy, and on the last tick of a poll the
//   three gyro values with sample_valid set.
//   The path is an input register, then the sequencer update into the result
//   register. Throughput is one word per cycle while the master side does not
//   stall; the single sequencer state update per word sets that figure.
//   When the master side stalls, the result register holds and the input
//   register fills; s_tready drops only when both are full.
//   Reset empties both stages, returns the sequencer to idle with SCL and SDA
//   released, clears the dead-poll counter and loads the default config.
//   Config writes are taken on cfg_we.
// ----------------------------------------------------------------------------
module i2c_gyro_poll_master
    import i2cgp_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    // Config write port
    input  logic        cfg_we,
    input  logic [1:0]  cfg_addr,
    input  logic [7:0]  cfg_wdata,
    // Input stream
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,   // sda_in[0], reg_addr[8:1], reg_data[16:9], zero pad
    input  logic [1:0]  s_tuser,   // op[1:0]
    // Result stream
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [55:0] m_tdata    // scl_out[0], sda_out[1], busy_res[2],
                                   // sample_valid[3], gyro_x[19:4], gyro_y[35:20],
                                   // gyro_z[51:36], wake_issued[52], zero pad
);

    cfg_t    cfg;
    item_t   in_item_reg;
    logic    in_valid_reg;
    result_t res_comb;
    result_t res_reg;
    logic    m_valid_reg;
    logic    out_free;
    logic    fire;

    i2cgp_cfg u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    assign out_free = !m_valid_reg || m_tready;
    assign fire     = in_valid_reg && out_free;
    assign s_tready = !in_valid_reg || out_free;

    // Input register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tready && s_tvalid) begin
            in_item_reg.op       <= s_tuser;
            in_item_reg.sda_in   <= s_tdata[0];
            in_item_reg.reg_addr <= s_tdata[8:1];
            in_item_reg.reg_data <= s_tdata[16:9];
        end
    end

    i2cgp_seq u_seq (
        .aclk    (aclk),
        .aresetn (aresetn),
        .fire    (fire),
        .item    (in_item_reg),
        .cfg     (cfg),
        .res     (res_comb)
    );

    // Result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (fire) begin
            m_valid_reg <= 1'b1;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (fire) begin
            res_reg <= res_comb;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {3'b000, res_reg.wake_issued, res_reg.gyro_z, res_reg.gyro_y,
                       res_reg.gyro_x, res_reg.sample_valid, res_reg.busy_res,
                       res_reg.sda_out, res_reg.scl_out};

    // A wake write only comes out of a completed poll and leaves the bus busy
    a_wake_after_poll: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg && res_reg.wake_issued |-> res_reg.sample_valid && res_reg.busy_res)
        else $error("wake issued without a completed poll");

    // A finished poll without a wake leaves the bus idle and released
    a_poll_ends_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg && res_reg.sample_valid && !res_reg.wake_issued
        |-> !res_reg.busy_res && res_reg.scl_out && res_reg.sda_out)
        else $error("poll completion left the bus busy");

    // Gyro fields are zero outside a poll completion
    a_gyro_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg && !res_reg.sample_valid
        |-> res_reg.gyro_x == 16'sd0 && res_reg.gyro_y == 16'sd0
            && res_reg.gyro_z == 16'sd0)
        else $error("gyro data without sample_valid");

    // A free result register always lets the next word in
    a_ready_when_free: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_valid_reg |-> s_tready)
        else $error("input stalled with an empty result register");

endmodule
